>>> src/ttqc_pkg.sv
// ----------------------------------------------------------------------------
// ttqc_pkg: shared types and constants for the text tokenizer
// Character codes, parse modes, token operations, result and queue entry
// layouts, and the single-character token test used by the front end.
// ----------------------------------------------------------------------------
package ttqc_pkg;

   // Sizes of the configuration and result fields.
   localparam int BYTE_W             = 8;
   localparam int CAP_W              = 13;
   localparam int LEN_W              = 12;
   localparam int MAX_TOKEN_CAPACITY = 4096;
   // The length field holds 12 bits, so the capacity never goes past 4096.
   localparam int CAP_LIMIT = (MAX_TOKEN_CAPACITY < 4096) ? MAX_TOKEN_CAPACITY : 4096;
   localparam logic [CAP_W-1:0] CAP_RESET = 13'd1024;

   // One text byte causes at most this many result words.
   localparam int RES_PER_ITEM = 4;
   localparam int SLOT_W       = $clog2(RES_PER_ITEM);
   localparam int NRES_W       = $clog2(RES_PER_ITEM + 1);

   // Queue between front and back end.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Register port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Stream widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CH_APOS   = 8'h27;
   localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

   // Register indexes.
   typedef enum logic [1:0] {
      REG_CAPACITY      = 2'd0,
      REG_HASH_COMMENTS = 2'd1,
      REG_IGNORE_BRKTS  = 2'd2,
      REG_COLON_SINGLE  = 2'd3
   } reg_index_type;

   // Parse modes.
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_COMMENT = 3'd2,
      MODE_WORD    = 3'd3,
      MODE_QUOTE   = 3'd4,
      MODE_QBACK   = 3'd5
   } mode_type;

   // Token operations that one text byte expands into.
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_KEEP   = 3'd1,
      OP_CLOSE  = 3'd2,
      OP_START  = 3'd3,
      OP_QSTART = 3'd4
   } op_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic             hash_comments;
      logic             ignore_brackets;
      logic             colon_single;
   } cfg_type;

   typedef struct packed {
      logic              is_end;
      logic [BYTE_W-1:0] tbyte;
      logic [LEN_W-1:0]  len;
      logic              quoted;
      logic              ovf;
   } result_type;

   typedef struct packed {
      logic [NRES_W-1:0]                count;
      result_type [RES_PER_ITEM-1:0]    res;
   } bundle_type;

   // True for bytes that form a token of their own.
   function automatic logic is_single(input logic [BYTE_W-1:0] c, input cfg_type cfg);
      logic hit;
      hit = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_APOS) || (c == CH_COMMA);
      if (!cfg.ignore_brackets && ((c == CH_LPAREN) || (c == CH_RPAREN))) begin
         hit = 1'b1;
      end
      if (cfg.colon_single && (c == CH_COLON)) begin
         hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

>>> src/ttqc_front.sv
// ----------------------------------------------------------------------------
// ttqc_front: byte classifier and token state
// Takes one text byte a cycle while the queue is not full, runs the parse mode
// machine, and turns the byte into a bundle of up to four finished result words for the queue.
// ----------------------------------------------------------------------------
module ttqc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  ttqc_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [ttqc_pkg::BYTE_W-1:0] in_byte,
   input  logic                        fifo_full,
   output logic                        push,
   output ttqc_pkg::bundle_type        push_data
);

   ttqc_pkg::mode_type                  mode_ff, mode_in;
   logic [ttqc_pkg::LEN_W-1:0]          cnt_ff, cnt_in;
   logic                                ovf_ff, ovf_in;
   logic                                quoted_ff, quoted_in;

   ttqc_pkg::op_type [ttqc_pkg::RES_PER_ITEM-1:0]                    ops;
   logic [ttqc_pkg::RES_PER_ITEM-1:0][ttqc_pkg::BYTE_W-1:0]          ops_byte;

   logic [ttqc_pkg::CAP_W-1:0]          cap_eff;
   logic [ttqc_pkg::NRES_W-1:0]         acc_n;
   ttqc_pkg::result_type [ttqc_pkg::RES_PER_ITEM-1:0] acc_res;

   logic accept;
   logic is_ws, is_sng, is_slash, is_hash, is_dq, is_bs, is_nul, is_nl;

   // Handshake: the front stalls only on a full queue.
   assign in_ready = !fifo_full;
   assign accept   = in_valid && !fifo_full;

   // Byte classes.
   assign is_ws    = (in_byte <= ttqc_pkg::CH_SPACE);
   assign is_sng   = ttqc_pkg::is_single(in_byte, cfg);
   assign is_slash = (in_byte == ttqc_pkg::CH_SLASH);
   assign is_hash  = (in_byte == ttqc_pkg::CH_HASH) && cfg.hash_comments;
   assign is_dq    = (in_byte == ttqc_pkg::CH_DQUOTE);
   assign is_bs    = (in_byte == ttqc_pkg::CH_BSLASH);
   assign is_nul   = (in_byte == ttqc_pkg::CH_NUL);
   assign is_nl    = (in_byte == ttqc_pkg::CH_NL);

   // Capacity limited to what the length field can hold.
   assign cap_eff = (cfg.capacity > ttqc_pkg::CAP_W'(ttqc_pkg::CAP_LIMIT)) ?
                    ttqc_pkg::CAP_W'(ttqc_pkg::CAP_LIMIT) : cfg.capacity;

   // Next parse mode.
   always_comb begin
      mode_in = ttqc_pkg::MODE_IDLE;
      unique case (mode_ff)
         ttqc_pkg::MODE_SLASH: begin
            priority if (is_slash)      mode_in = ttqc_pkg::MODE_COMMENT;
            else if (is_ws || is_sng)   mode_in = ttqc_pkg::MODE_IDLE;
            else                        mode_in = ttqc_pkg::MODE_WORD;
         end
         ttqc_pkg::MODE_COMMENT: begin
            mode_in = (is_nul || is_nl) ? ttqc_pkg::MODE_IDLE : ttqc_pkg::MODE_COMMENT;
         end
         ttqc_pkg::MODE_WORD: begin
            mode_in = (is_ws || is_sng) ? ttqc_pkg::MODE_IDLE : ttqc_pkg::MODE_WORD;
         end
         ttqc_pkg::MODE_QUOTE: begin
            priority if (is_nul || is_dq) mode_in = ttqc_pkg::MODE_IDLE;
            else if (is_bs)               mode_in = ttqc_pkg::MODE_QBACK;
            else                          mode_in = ttqc_pkg::MODE_QUOTE;
         end
         ttqc_pkg::MODE_QBACK: begin
            priority if (is_dq) mode_in = ttqc_pkg::MODE_QUOTE;
            else if (is_nul)    mode_in = ttqc_pkg::MODE_IDLE;
            else if (is_bs)     mode_in = ttqc_pkg::MODE_QBACK;
            else                mode_in = ttqc_pkg::MODE_QUOTE;
         end
         default: begin
            // Idle, and any unused code, which behaves as idle.
            priority if (is_ws) mode_in = ttqc_pkg::MODE_IDLE;
            else if (is_slash)  mode_in = ttqc_pkg::MODE_SLASH;
            else if (is_hash)   mode_in = ttqc_pkg::MODE_COMMENT;
            else if (is_dq)     mode_in = ttqc_pkg::MODE_QUOTE;
            else if (is_sng)    mode_in = ttqc_pkg::MODE_IDLE;
            else                mode_in = ttqc_pkg::MODE_WORD;
         end
      endcase
   end

   // Token operations caused by this byte, in order.
   always_comb begin
      ops      = {ttqc_pkg::RES_PER_ITEM{ttqc_pkg::OP_NONE}};
      ops_byte = {ttqc_pkg::RES_PER_ITEM{in_byte}};
      unique case (mode_ff)
         ttqc_pkg::MODE_SLASH: begin
            if (!is_slash) begin
               // The waiting slash opens a word; the byte extends it, or closes it and may be a token itself.
               ops[0]      = ttqc_pkg::OP_START;
               ops_byte[0] = ttqc_pkg::CH_SLASH;
               priority if (is_ws) begin
                  ops[1] = ttqc_pkg::OP_CLOSE;
               end else if (is_sng) begin
                  ops[1] = ttqc_pkg::OP_CLOSE;
                  ops[2] = ttqc_pkg::OP_START;
                  ops[3] = ttqc_pkg::OP_CLOSE;
               end else begin
                  ops[1] = ttqc_pkg::OP_KEEP;
               end
            end
         end
         ttqc_pkg::MODE_COMMENT: begin
            ops[0] = ttqc_pkg::OP_NONE;
         end
         ttqc_pkg::MODE_WORD: begin
            priority if (is_ws) begin
               ops[0] = ttqc_pkg::OP_CLOSE;
            end else if (is_sng) begin
               ops[0] = ttqc_pkg::OP_CLOSE;
               ops[1] = ttqc_pkg::OP_START;
               ops[2] = ttqc_pkg::OP_CLOSE;
            end else begin
               ops[0] = ttqc_pkg::OP_KEEP;
            end
         end
         ttqc_pkg::MODE_QUOTE: begin
            priority if (is_nul || is_dq) begin
               ops[0] = ttqc_pkg::OP_CLOSE;
            end else if (is_bs) begin
               ops[0] = ttqc_pkg::OP_NONE;
            end else begin
               ops[0] = ttqc_pkg::OP_KEEP;
            end
         end
         ttqc_pkg::MODE_QBACK: begin
            ops[0] = ttqc_pkg::OP_KEEP;
            if (is_dq) begin
               // Escaped quote.
               ops_byte[0] = ttqc_pkg::CH_DQUOTE;
            end else begin
               // The backslash is kept; the byte is then kept too, ends the token (NUL), or waits (backslash).
               ops_byte[0] = ttqc_pkg::CH_BSLASH;
               priority if (is_nul) begin
                  ops[1] = ttqc_pkg::OP_CLOSE;
               end else if (is_bs) begin
                  ops[1] = ttqc_pkg::OP_NONE;
               end else begin
                  ops[1] = ttqc_pkg::OP_KEEP;
               end
            end
         end
         default: begin
            priority if (is_ws || is_slash || is_hash) begin
               ops[0] = ttqc_pkg::OP_NONE;
            end else if (is_dq) begin
               ops[0] = ttqc_pkg::OP_QSTART;
            end else if (is_sng) begin
               ops[0] = ttqc_pkg::OP_START;
               ops[1] = ttqc_pkg::OP_CLOSE;
            end else begin
               ops[0] = ttqc_pkg::OP_START;
            end
         end
      endcase
   end

   // Walk the operations: count kept bytes, drop those past capacity, and
   // pack the produced results without gaps.
   always_comb begin
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      quoted_in = quoted_ff;
      acc_n     = '0;
      acc_res   = '0;
      for (int i = 0; i < ttqc_pkg::RES_PER_ITEM; i++) begin
         if ((ops[i] == ttqc_pkg::OP_START) || (ops[i] == ttqc_pkg::OP_QSTART)) begin
            cnt_in    = '0;
            ovf_in    = 1'b0;
            quoted_in = (ops[i] == ttqc_pkg::OP_QSTART);
         end
         if ((ops[i] == ttqc_pkg::OP_START) || (ops[i] == ttqc_pkg::OP_KEEP)) begin
            if (({1'b0, cnt_in} + ttqc_pkg::CAP_W'(1)) < cap_eff) begin
               acc_res[acc_n[ttqc_pkg::SLOT_W-1:0]].is_end = 1'b0;
               acc_res[acc_n[ttqc_pkg::SLOT_W-1:0]].tbyte  = ops_byte[i];
               acc_n  = acc_n + ttqc_pkg::NRES_W'(1);
               cnt_in = cnt_in + ttqc_pkg::LEN_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         if (ops[i] == ttqc_pkg::OP_CLOSE) begin
            acc_res[acc_n[ttqc_pkg::SLOT_W-1:0]].is_end = 1'b1;
            acc_res[acc_n[ttqc_pkg::SLOT_W-1:0]].len    = cnt_in;
            acc_res[acc_n[ttqc_pkg::SLOT_W-1:0]].quoted = quoted_in;
            acc_res[acc_n[ttqc_pkg::SLOT_W-1:0]].ovf    = ovf_in;
            acc_n     = acc_n + ttqc_pkg::NRES_W'(1);
            cnt_in    = '0;
            ovf_in    = 1'b0;
            quoted_in = 1'b0;
         end
      end
   end

   // Queue write: only bytes that produce results take an entry.
   assign push            = accept && (acc_n != '0);
   assign push_data.count = acc_n;
   assign push_data.res   = acc_res;

   // Parse state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ttqc_pkg::MODE_IDLE;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         quoted_ff <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         quoted_ff <= quoted_in;
      end
   end

endmodule

>>> src/ttqc_fifo.sv
// ----------------------------------------------------------------------------
// ttqc_fifo: result bundle queue
// Short queue of result bundles that lets the front end and the output
// serializer stall independently.
// ----------------------------------------------------------------------------
module ttqc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ttqc_pkg::bundle_type push_data,
   output logic                 full,
   input  logic                 pop,
   output ttqc_pkg::bundle_type head,
   output logic                 empty
);

   ttqc_pkg::bundle_type              store_ff [ttqc_pkg::FIFO_DEPTH];
   logic [ttqc_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ttqc_pkg::FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ttqc_pkg::FIFO_CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == ttqc_pkg::FIFO_CNT_W'(ttqc_pkg::FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + ttqc_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + ttqc_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + ttqc_pkg::FIFO_CNT_W'(1);
         2'b01:   count_in = count_ff - ttqc_pkg::FIFO_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("bundle pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("bundle popped from an empty queue");

   a_bundle_count_range: assert property (@(posedge clock) disable iff (reset)
      push |-> ((push_data.count != '0) &&
                (push_data.count <= ttqc_pkg::NRES_W'(ttqc_pkg::RES_PER_ITEM))))
      else $error("bundle with an impossible result count");
`endif

endmodule

>>> src/ttqc_back.sv
// ----------------------------------------------------------------------------
// ttqc_back: result serializer
// Steps through the results of the bundle at the queue head, one word per
// cycle while out_ready allows, into the output register, and marks the last word of each byte.
// ----------------------------------------------------------------------------
module ttqc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ttqc_pkg::bundle_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ttqc_pkg::result_type out_res,
   output logic                 out_last
);

   logic [ttqc_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                        valid_ff, valid_in;
   ttqc_pkg::result_type        res_ff;
   logic                        last_ff;

   logic load;
   logic last_slot;

   // The output register loads whenever the queue has a bundle and the register is empty or being drained.
   assign load      = !empty && (!valid_ff || out_ready);
   assign last_slot = ((ttqc_pkg::NRES_W'(slot_ff) + ttqc_pkg::NRES_W'(1)) == head.count);
   assign pop       = load && last_slot;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (load) begin
         slot_in  = last_slot ? '0 : slot_ff + ttqc_pkg::SLOT_W'(1);
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Output word.
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.res[slot_ff];
         last_ff <= last_slot;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_last  = last_ff;

endmodule

>>> src/text_tokenizer_quotes_comments.sv
// The result words of an accepted byte pass through the bundle queue and the output register.
// Throughput: one text byte a cycle in while the queue has room, one result word a cycle out
// while rsp_tready allows; a k-word byte holds the output for its k words; the 4-entry bundle queue absorbs bursts.
// Bytes that make no words (whitespace, comments, waiting slash) never touch the queue.
// Reset is synchronous and active high: it clears the parse state, the queue and the
// output register, and sets the registers to capacity 1024 with all flags off.
// ----------------------------------------------------------------------------
// text_tokenizer_quotes_comments: streaming text tokenizer
// Splits a stream of text bytes into word, quoted and single-character tokens,
// skipping comments, with a register port for capacity and syntax options.
// ----------------------------------------------------------------------------
module text_tokenizer_quotes_comments (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ttqc_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] text_byte
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] token_byte, [19:8] token_length, [20] quoted_token,
   // [21] overflow_flag, [23:22] zero
   output logic [ttqc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [ttqc_pkg::RSP_USER_W-1:0] rsp_tuser,   // [0] byte_valid, [1] end_of_token
   output logic                            rsp_tlast,   // last_of_input
   // Register port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ttqc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ttqc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ttqc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   ttqc_pkg::cfg_type       cfg_ff, cfg_in;
   ttqc_pkg::reg_index_type reg_sel;
   logic                    csr_write;

   logic                    fifo_full, fifo_empty, push, pop;
   ttqc_pkg::bundle_type    push_data, head;
   ttqc_pkg::result_type    out_res;

   // Register port decode.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = ttqc_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            ttqc_pkg::REG_CAPACITY:      cfg_in.capacity = csr_pwdata[ttqc_pkg::CAP_W-1:0];
            ttqc_pkg::REG_HASH_COMMENTS: cfg_in.hash_comments   = csr_pwdata[0];
            ttqc_pkg::REG_IGNORE_BRKTS:  cfg_in.ignore_brackets = csr_pwdata[0];
            ttqc_pkg::REG_COLON_SINGLE:  cfg_in.colon_single    = csr_pwdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity        <= ttqc_pkg::CAP_RESET;
         cfg_ff.hash_comments   <= 1'b0;
         cfg_ff.ignore_brackets <= 1'b0;
         cfg_ff.colon_single    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read back.
   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         ttqc_pkg::REG_CAPACITY:
            csr_prdata = ttqc_pkg::CSR_DATA_W'(cfg_ff.capacity);
         ttqc_pkg::REG_HASH_COMMENTS:
            csr_prdata = ttqc_pkg::CSR_DATA_W'(cfg_ff.hash_comments);
         ttqc_pkg::REG_IGNORE_BRKTS:
            csr_prdata = ttqc_pkg::CSR_DATA_W'(cfg_ff.ignore_brackets);
         ttqc_pkg::REG_COLON_SINGLE:
            csr_prdata = ttqc_pkg::CSR_DATA_W'(cfg_ff.colon_single);
         default:
            csr_prdata = '0;
      endcase
   end

   // Front end: classify bytes and build result bundles.
   ttqc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata[ttqc_pkg::BYTE_W-1:0]),
      .fifo_full (fifo_full),
      .push      (push),
      .push_data (push_data)
   );

   ttqc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .head      (head),
      .empty     (fifo_empty)
   );

   // Back end: one result word per cycle while rsp_tready allows.
   ttqc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (fifo_empty),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res),
      .out_last  (rsp_tlast)
   );

   // Pack the result word.
   assign rsp_tdata = {2'b00, out_res.ovf, out_res.quoted, out_res.len, out_res.tbyte};
   assign rsp_tuser = {out_res.is_end, !out_res.is_end};

endmodule
